// ===== hdl/wstq_pkg.sv =====
// Shared sizes, codes and state encoding for the work-stealing task deques.
// No dependencies; imported by work_stealing_task_queues_core.
package wstq_pkg;

   // Sizing (QUEUE_DEPTH must be a power of two: slot index wraps by truncation)
   localparam int MAX_WORKERS = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int TASK_BITS   = 32;

   // Fixed field widths of the ports
   localparam int CFG_W    = 4;
   localparam int RAW_W    = 8;
   localparam int HANDLE_W = 32;
   localparam int SRC_W    = 3;
   localparam int LVL_OUT_W = 5;

   // Derived widths
   localparam int WID_W    = $clog2(MAX_WORKERS);
   localparam int CNT_W    = $clog2(MAX_WORKERS + 1);
   localparam int REM_W    = WID_W + 1;
   localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W   = WID_W + SLOT_W;
   localparam int STORE_W  = (TASK_BITS < HANDLE_W) ? TASK_BITS : HANDLE_W;
   localparam int DIVC_W   = $clog2(RAW_W);
   localparam int MEM_DEPTH = MAX_WORKERS * QUEUE_DEPTH;

   // Item kinds
   localparam logic KIND_SUBMIT = 1'b0;
   localparam logic KIND_FETCH  = 1'b1;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_LOOK = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

endpackage

// ===== hdl/work_stealing_task_queues_core.sv =====
// Work-stealing task deques: one bounded deque per worker, push/pop/steal.
// Depends on wstq_pkg (sizes, kind codes, sequencer state type).
//
// Channel   | Direction | Ports                            | Contents (low bit first)
// ----------+-----------+----------------------------------+--------------------------------
// request   | in        | req_tvalid/req_tready/tdata/tuser| tuser: kind; tdata: worker index,
//           |           |                                  |   task_handle
// response  | out       | rsp_tvalid/rsp_tready/rsp_tdata  | accepted, found, task_out,
//           |           |                                  |   stolen, source_worker, queue_level
// csr       | in        | csr_valid/csr_ready/csr_data     | worker_count (clears all deques)
//
// Sequencing: one transaction at a time. After acceptance a shared 4-bit
// compare/subtract unit reduces the worker index modulo the worker count,
// the addressed deque is examined, a fetch that finds its own deque empty
// walks the other deques one per cycle, and the response register is
// loaded; the sequencer then returns to idle before the next request is taken.
// Reset: synchronous, active high; all deques empty, worker_count = 8.
// Stalls: a held response only delays the final load; req_tready stays low
// until the sequencer returns to idle. The task store has no reset.
module work_stealing_task_queues_core (
   input  logic                          clock,
   input  logic                          reset,
   // request: tuser = {kind}; tdata = {worker[7:0], task_handle[39:8]}
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [39:0]                   req_tdata,
   input  logic [0:0]                    req_tuser,
   // response: tdata = {accepted[0], found[1], task_out[33:2], stolen[34],
   //                    source_worker[37:35], queue_level[42:38], pad[47:43]}
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [47:0]                   rsp_tdata,
   // configuration write: worker_count
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wstq_pkg::CFG_W-1:0]    csr_data
);
   import wstq_pkg::*;

   // Sequencer and item registers
   state_type             state_ff, state_in;
   logic                  kind_ff, kind_in;
   logic [RAW_W-1:0]      raw_ff, raw_in;
   logic [STORE_W-1:0]    handle_ff, handle_in;
   logic [RAW_W-1:0]      dvd_ff, dvd_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [DIVC_W-1:0]     divc_ff, divc_in;
   logic [WID_W-1:0]      w_ff, w_in;
   logic [WID_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   // Step outcome
   logic                  accepted_ff, accepted_in;
   logic                  found_ff, found_in;
   logic                  stolen_ff, stolen_in;
   logic [WID_W-1:0]      src_ff, src_in;

   // Deque bookkeeping
   logic [SLOT_W-1:0]     front_ff [MAX_WORKERS];
   logic [SLOT_W-1:0]     front_in [MAX_WORKERS];
   logic [LEVEL_W-1:0]    occ_ff   [MAX_WORKERS];
   logic [LEVEL_W-1:0]    occ_in   [MAX_WORKERS];

   // Task store
   logic [STORE_W-1:0]    task_mem [MEM_DEPTH];
   logic [STORE_W-1:0]    mem_q_ff;
   logic                  mem_we, mem_re;
   logic [ADDR_W-1:0]     mem_addr;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_acc_ff, rsp_acc_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [HANDLE_W-1:0]   rsp_task_ff, rsp_task_in;
   logic                  rsp_stolen_ff, rsp_stolen_in;
   logic [SRC_W-1:0]      rsp_src_ff, rsp_src_in;
   logic [LVL_OUT_W-1:0]  rsp_level_ff, rsp_level_in;

   // Shared unit operands and helpers
   logic [REM_W-1:0]      div_t;
   logic [REM_W-1:0]      div_r;
   logic [LEVEL_W-1:0]    cur_occ;
   logic [SLOT_W-1:0]     cur_front;
   logic [SLOT_W-1:0]     slot_push;
   logic [SLOT_W-1:0]     slot_back;
   logic [WID_W-1:0]      idx_next;
   logic [CFG_W-1:0]      cfg_v;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_level_ff, rsp_src_ff, rsp_stolen_ff, rsp_task_ff,
                        rsp_found_ff, rsp_acc_ff};

   // Everything reads the bookkeeping at the sequencer index only
   assign cur_occ   = occ_ff[idx_ff];
   assign cur_front = front_ff[idx_ff];
   assign slot_push = cur_front + SLOT_W'(cur_occ);
   assign slot_back = cur_front + SLOT_W'(cur_occ - LEVEL_W'(1));
   assign idx_next  = ((CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff) ? '0 : idx_ff + WID_W'(1);

   // One restoring-division step: shift in the next dividend bit, subtract if it fits
   assign div_t = {rem_ff[REM_W-2:0], dvd_ff[RAW_W-1]};
   assign div_r = (div_t >= REM_W'(cnt_ff)) ? div_t - REM_W'(cnt_ff) : div_t;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      raw_in        = raw_ff;
      handle_in     = handle_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      divc_in       = divc_ff;
      w_in          = w_ff;
      idx_in        = idx_ff;
      scan_in       = scan_ff;
      cnt_in        = cnt_ff;
      accepted_in   = accepted_ff;
      found_in      = found_ff;
      stolen_in     = stolen_ff;
      src_in        = src_ff;
      front_in      = front_ff;
      occ_in        = occ_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = {idx_ff, cur_front};
      rsp_acc_in    = rsp_acc_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_stolen_in = rsp_stolen_ff;
      rsp_src_in    = rsp_src_ff;
      rsp_level_in  = rsp_level_ff;
      cfg_v         = csr_data;

      // Drop the response once taken
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in     = req_tuser[0];
               raw_in      = req_tdata[RAW_W-1:0];
               handle_in   = req_tdata[RAW_W +: STORE_W];
               dvd_in      = req_tdata[RAW_W-1:0];
               rem_in      = '0;
               divc_in     = '0;
               accepted_in = 1'b0;
               found_in    = 1'b0;
               stolen_in   = 1'b0;
               src_in      = '0;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            // Reduce the worker index modulo the worker count, one bit per cycle
            rem_in  = div_r;
            dvd_in  = dvd_ff << 1;
            divc_in = divc_ff + DIVC_W'(1);
            if (divc_ff == DIVC_W'(RAW_W - 1)) begin
               w_in     = div_r[WID_W-1:0];
               idx_in   = div_r[WID_W-1:0];
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (kind_ff == KIND_SUBMIT) begin
               // Push at the back unless full
               if (cur_occ < LEVEL_W'(QUEUE_DEPTH)) begin
                  mem_we         = 1'b1;
                  mem_addr       = {idx_ff, slot_push};
                  occ_in[idx_ff] = cur_occ + LEVEL_W'(1);
                  accepted_in    = 1'b1;
               end
               state_in = ST_DONE;
            end else if (cur_occ != '0) begin
               // Pop own front
               mem_re           = 1'b1;
               mem_addr         = {idx_ff, cur_front};
               front_in[idx_ff] = cur_front + SLOT_W'(1);
               occ_in[idx_ff]   = cur_occ - LEVEL_W'(1);
               found_in         = 1'b1;
               src_in           = idx_ff;
               state_in         = ST_DONE;
            end else begin
               // Own deque empty: start the victim walk at the next worker
               idx_in   = idx_next;
               scan_in  = CNT_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff >= cnt_ff) begin
               idx_in   = w_ff;
               state_in = ST_DONE;
            end else if (cur_occ != '0) begin
               // Steal from the victim's back
               mem_re         = 1'b1;
               mem_addr       = {idx_ff, slot_back};
               occ_in[idx_ff] = cur_occ - LEVEL_W'(1);
               found_in       = 1'b1;
               stolen_in      = 1'b1;
               src_in         = idx_ff;
               idx_in         = w_ff;
               state_in       = ST_DONE;
            end else begin
               idx_in  = idx_next;
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            // Hold until the response register is free, then load it
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_acc_in    = accepted_ff;
               rsp_found_in  = found_ff;
               rsp_task_in   = found_ff ? HANDLE_W'(mem_q_ff) : '0;
               rsp_stolen_in = stolen_ff;
               rsp_src_in    = SRC_W'(src_ff);
               rsp_level_in  = (raw_ff < RAW_W'(cnt_ff)) ? LVL_OUT_W'(cur_occ) : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Worker count write: clamp to the legal range and empty every deque
      if (csr_valid) begin
         if (cfg_v == '0) begin
            cnt_in = CNT_W'(1);
         end else if (cfg_v > CFG_W'(MAX_WORKERS)) begin
            cnt_in = CNT_W'(MAX_WORKERS);
         end else begin
            cnt_in = CNT_W'(cfg_v);
         end
         for (int i = 0; i < MAX_WORKERS; i++) begin
            front_in[i] = '0;
            occ_in[i]   = '0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= CNT_W'(MAX_WORKERS);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_WORKERS; i++) begin
            front_ff[i] <= '0;
            occ_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
      end
   end

   // Item and response payload
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      raw_ff        <= raw_in;
      handle_ff     <= handle_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      divc_ff       <= divc_in;
      w_ff          <= w_in;
      idx_ff        <= idx_in;
      scan_ff       <= scan_in;
      accepted_ff   <= accepted_in;
      found_ff      <= found_in;
      stolen_ff     <= stolen_in;
      src_ff        <= src_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_stolen_ff <= rsp_stolen_in;
      rsp_src_ff    <= rsp_src_in;
      rsp_level_ff  <= rsp_level_in;
   end

   // Task store: one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         task_mem[mem_addr] <= handle_ff;
      end
      if (mem_re) begin
         mem_q_ff <= task_mem[mem_addr];
      end
   end

endmodule
